>>> rtl/pgq_pkg.sv
package pgq_pkg;

  // Default geometry of the sums
  localparam int unsigned SUM_BITS    = 24;
  localparam int unsigned FRAC_BITS   = 14;

  // sample_scale register: unsigned Q1.16 held in 17 bits
  localparam int unsigned SCALE_WIDTH = 17;
  localparam int unsigned SCALE_FRAC  = 16;
  localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = SCALE_WIDTH'(65536);

  // Output code width; one code bit is resolved per search stage
  localparam int unsigned KBITS       = 8;

  // Gain 255.99 = 25599 / 100, both sides squared
  localparam longint unsigned GAIN_SQ     = 64'd655308801;
  localparam longint unsigned GAIN_DEN_SQ = 64'd10000;

  // Smallest product p for which code k is reached:
  //   ceil(10000 * k^2 * 2^(frac+16) / 25599^2)
  // Evaluated at elaboration only, to build constant threshold tables.
  function automatic logic [63:0] thresh_f(input int unsigned code, input int unsigned frac);
    logic [127:0] num;
    num = 128'(GAIN_DEN_SQ) * 128'(code) * 128'(code);
    num = num << (frac + SCALE_FRAC);
    num = num + 128'(GAIN_SQ - 64'd1);
    return 64'(num / 128'(GAIN_SQ));
  endfunction

endpackage

>>> rtl/pgq_mult.sv
// Scale stage: three sum * sample_scale products, registered.
module pgq_mult #(
  parameter int unsigned SumBits = pgq_pkg::SUM_BITS
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             valid_i,
  input  logic [SumBits-1:0]                               red_sum_i,
  input  logic [SumBits-1:0]                               green_sum_i,
  input  logic [SumBits-1:0]                               blue_sum_i,
  input  logic [pgq_pkg::SCALE_WIDTH-1:0]                  scale_i,
  output logic                                             valid_o,
  output logic [2:0][SumBits+pgq_pkg::SCALE_WIDTH-1:0]     prod_o
);

  localparam int unsigned ProdW = SumBits + pgq_pkg::SCALE_WIDTH;

  logic                  valid_q;
  logic [2:0][ProdW-1:0] prod_d, prod_q;

  always_comb begin
    prod_d[0] = ProdW'(red_sum_i)   * ProdW'(scale_i);
    prod_d[1] = ProdW'(green_sum_i) * ProdW'(scale_i);
    prod_d[2] = ProdW'(blue_sum_i)  * ProdW'(scale_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

>>> rtl/pgq_step.sv
// One binary-search stage: decides code bit Bit for all three channels
// by comparing the product against a constant threshold.
module pgq_step #(
  parameter int unsigned SumBits  = pgq_pkg::SUM_BITS,
  parameter int unsigned FracBits = pgq_pkg::FRAC_BITS,
  parameter int unsigned Bit      = 0
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             valid_i,
  input  logic [2:0][SumBits+pgq_pkg::SCALE_WIDTH-1:0]     prod_i,
  input  logic [2:0][pgq_pkg::KBITS-1:0]                   code_i,
  output logic                                             valid_o,
  output logic [2:0][SumBits+pgq_pkg::SCALE_WIDTH-1:0]     prod_o,
  output logic [2:0][pgq_pkg::KBITS-1:0]                   code_o
);

  localparam int unsigned ProdW   = SumBits + pgq_pkg::SCALE_WIDTH;
  localparam int unsigned ThW     = FracBits + pgq_pkg::SCALE_FRAC;
  localparam int unsigned CmpW    = (ProdW > ThW) ? ProdW : ThW;
  localparam int unsigned Entries = 2 ** pgq_pkg::KBITS;
  localparam logic [pgq_pkg::KBITS-1:0] BitMask = pgq_pkg::KBITS'(1) << Bit;

  // Constant threshold table; threshold of the top code is below 2^ThW
  logic [ThW-1:0] thresh_w [Entries];

  for (genvar g = 0; g < Entries; g++) begin : g_thresh
    localparam logic [63:0] Th = pgq_pkg::thresh_f(g, FracBits);
    assign thresh_w[g] = Th[ThW-1:0];
  end

  logic                                valid_q;
  logic [2:0][ProdW-1:0]               prod_q;
  logic [2:0][pgq_pkg::KBITS-1:0]      code_d, code_q;
  logic [2:0][pgq_pkg::KBITS-1:0]      trial;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c]  = code_i[c] | BitMask;
      code_d[c] = (CmpW'(prod_i[c]) >= CmpW'(thresh_w[trial[c]])) ? trial[c] : code_i[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      prod_q <= prod_i;
      code_q <= code_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;
  assign code_o  = code_q;

endmodule

>>> rtl/pixel_gamma_quantizer_unit.sv
// Gamma-2 pixel quantizer. A transaction is taken on every clock edge with
// start_i high (busy_o is never raised), so a pixel can enter in every
// cycle. Each transaction gives exactly one result: done_o is driven by the
// valid bit of the last search stage register and is high for one cycle,
// with the three bytes alongside.
// The receiver cannot hold results off and there is no backpressure; the
// result ports change every cycle in which a new pixel arrives at the end.
// The pipeline is one scale stage (sum * sample_scale) followed by eight
// binary-search stages, one per output bit, each comparing the scaled sum
// against a constant threshold table. Byte = min(255, floor(255.99*sqrt(avg))),
// computed exactly. sample_scale (Q1.16, reset = one sample) is written
// with sample_scale_we_i and should only change while no pixel is in flight.
module pixel_gamma_quantizer_unit #(
  parameter int unsigned SumBits  = pgq_pkg::SUM_BITS,
  parameter int unsigned FracBits = pgq_pkg::FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // pixel transaction
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [SumBits-1:0]               red_sum_i,
  input  logic [SumBits-1:0]               green_sum_i,
  input  logic [SumBits-1:0]               blue_sum_i,
  // result
  output logic                             done_o,
  output logic [7:0]                       red_byte_o,
  output logic [7:0]                       green_byte_o,
  output logic [7:0]                       blue_byte_o,
  // configuration
  input  logic                             sample_scale_we_i,
  input  logic [pgq_pkg::SCALE_WIDTH-1:0]  sample_scale_i
);

  localparam int unsigned ProdW   = SumBits + pgq_pkg::SCALE_WIDTH;
  localparam int unsigned Steps   = pgq_pkg::KBITS;
  localparam int unsigned Latency = Steps + 1;

  // Scale register
  logic [pgq_pkg::SCALE_WIDTH-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= pgq_pkg::SCALE_RESET;
    end else if (sample_scale_we_i) begin
      scale_q <= sample_scale_i;
    end
  end

  // Fully pipelined, never stalls
  assign busy_o = 1'b0;

  logic                               accept;
  logic [Steps:0]                     vld_w;
  logic [2:0][ProdW-1:0]              prod_w [Steps+1];
  logic [2:0][pgq_pkg::KBITS-1:0]     code_w [Steps+1];

  assign accept = start_i && !busy_o;

  pgq_mult #(
    .SumBits (SumBits)
  ) u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .red_sum_i   (red_sum_i),
    .green_sum_i (green_sum_i),
    .blue_sum_i  (blue_sum_i),
    .scale_i     (scale_q),
    .valid_o     (vld_w[0]),
    .prod_o      (prod_w[0])
  );

  // Search starts from code zero; MSB is resolved first
  assign code_w[0] = '0;

  for (genvar i = 0; i < Steps; i++) begin : g_step
    pgq_step #(
      .SumBits  (SumBits),
      .FracBits (FracBits),
      .Bit      (Steps - 1 - i)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_w[i]),
      .prod_i  (prod_w[i]),
      .code_i  (code_w[i]),
      .valid_o (vld_w[i+1]),
      .prod_o  (prod_w[i+1]),
      .code_o  (code_w[i+1])
    );
  end

  // Last search stage register drives the result ports
  assign done_o       = vld_w[Steps];
  assign red_byte_o   = code_w[Steps][0];
  assign green_byte_o = code_w[Steps][1];
  assign blue_byte_o  = code_w[Steps][2];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // Every result traces back to an accepted transaction at fixed latency
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Latency))
    else $error("done_o without a transaction Latency cycles earlier");

  // Channels share one scale sample: equal sums must give equal bytes
  a_red_green_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(red_sum_i == green_sum_i, Latency)) |-> (red_byte_o == green_byte_o))
    else $error("red/green lanes disagree on equal sums");

  a_green_blue_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(green_sum_i == blue_sum_i, Latency)) |-> (green_byte_o == blue_byte_o))
    else $error("green/blue lanes disagree on equal sums");

endmodule

>>> sim/tb_pixel_gamma_quantizer_unit.sv
module tb_pixel_gamma_quantizer_unit;

  // Run limit in clock cycles
  localparam int unsigned CYCLE_LIMIT = 60000;
  // Cycles to let the pipeline settle after the last expected result
  localparam int unsigned SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_bytes_t;

  // Scoreboard: keeps its own copy of sample_scale, predicts the three gamma
  // bytes of each accepted pixel and matches them in order against done_o.
  class pixel_byte_scoreboard;
    logic [pgq_pkg::SCALE_WIDTH-1:0] scale;
    pixel_bytes_t expected_q[$];
    int unsigned fail_count;

    function new();
      scale = pgq_pkg::SCALE_RESET;
      fail_count = 0;
    endfunction

    // Largest code k in 0..255 with 10000 * k^2 * 2^30 <= 25599^2 * sum * scale,
    // i.e. min(255, floor(255.99 * sqrt(avg))) with no rounding anywhere.
    function logic [7:0] gamma_byte(logic [pgq_pkg::SUM_BITS-1:0] sum);
      logic [127:0] avg_side;
      logic [127:0] code_side;
      logic [7:0] code;
      logic [7:0] trial;
      avg_side = 128'(pgq_pkg::GAIN_SQ) * 128'(sum) * 128'(scale);
      code = '0;
      for (int b = pgq_pkg::KBITS - 1; b >= 0; b--) begin
        trial = code | (8'd1 << b);
        code_side = (128'(pgq_pkg::GAIN_DEN_SQ) * 128'(trial) * 128'(trial))
                    << (pgq_pkg::FRAC_BITS + pgq_pkg::SCALE_FRAC);
        if (code_side <= avg_side) code = trial;
      end
      return code;
    endfunction

    function void note_pixel(logic [pgq_pkg::SUM_BITS-1:0] r,
                             logic [pgq_pkg::SUM_BITS-1:0] g,
                             logic [pgq_pkg::SUM_BITS-1:0] b);
      pixel_bytes_t exp_bytes;
      exp_bytes.red   = gamma_byte(r);
      exp_bytes.green = gamma_byte(g);
      exp_bytes.blue  = gamma_byte(b);
      expected_q.insert(expected_q.size(), exp_bytes);
    endfunction

    function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pixel_bytes_t exp_bytes;
      if (expected_q.size() == 0) begin
        $error("result with no pixel outstanding: red %0d green %0d blue %0d", r, g, b);
        fail_count++;
        return;
      end
      exp_bytes = expected_q.pop_front();
      if (exp_bytes.red !== r) begin
        $error("red_byte: expected %0d, actual %0d", exp_bytes.red, r);
        fail_count++;
      end
      if (exp_bytes.green !== g) begin
        $error("green_byte: expected %0d, actual %0d", exp_bytes.green, g);
        fail_count++;
      end
      if (exp_bytes.blue !== b) begin
        $error("blue_byte: expected %0d, actual %0d", exp_bytes.blue, b);
        fail_count++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            start_i;
  logic                            busy_o;
  logic [pgq_pkg::SUM_BITS-1:0]    red_sum_i;
  logic [pgq_pkg::SUM_BITS-1:0]    green_sum_i;
  logic [pgq_pkg::SUM_BITS-1:0]    blue_sum_i;
  logic                            done_o;
  logic [7:0]                      red_byte_o;
  logic [7:0]                      green_byte_o;
  logic [7:0]                      blue_byte_o;
  logic                            sample_scale_we_i;
  logic [pgq_pkg::SCALE_WIDTH-1:0] sample_scale_i;

  pixel_byte_scoreboard byte_sb = new();
  int unsigned cycle_count = 0;

  pixel_gamma_quantizer_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .red_sum_i         (red_sum_i),
    .green_sum_i       (green_sum_i),
    .blue_sum_i        (blue_sum_i),
    .done_o            (done_o),
    .red_byte_o        (red_byte_o),
    .green_byte_o      (green_byte_o),
    .blue_byte_o       (blue_byte_o),
    .sample_scale_we_i (sample_scale_we_i),
    .sample_scale_i    (sample_scale_i)
  );

  // 20-unit clock period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run watchdog; a hang anywhere ends here as a failure
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result monitor. Outputs are read in the active region right after the
  // edge, so this sees the values of the cycle that the edge closes.
  // No backpressure exists: every done_o pulse is a result transaction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      byte_sb.check_pixel(red_byte_o, green_byte_o, blue_byte_o);
    end
  end

  // Present one pixel and hold it until an edge with busy_o low takes it.
  // start_i stays high on return so back-to-back pixels need no new NBA.
  task automatic send_pixel(input logic [pgq_pkg::SUM_BITS-1:0] r,
                            input logic [pgq_pkg::SUM_BITS-1:0] g,
                            input logic [pgq_pkg::SUM_BITS-1:0] b);
    start_i     <= 1'b1;
    red_sum_i   <= r;
    green_sum_i <= g;
    blue_sum_i  <= b;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    byte_sb.note_pixel(r, g, b);
  endtask

  task automatic idle_cycles(input int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Stop sending and wait until every predicted pixel has come back
  task automatic drain_results();
    start_i <= 1'b0;
    while (byte_sb.pending() != 0) @(posedge clk_i);
  endtask

  // sample_scale may only change with the pipeline empty. Each pixel gives a
  // result, so once the queue is empty nothing is in flight; the task still
  // idles before it writes the register anyway.
  task automatic write_scale(input logic [pgq_pkg::SCALE_WIDTH-1:0] value);
    drain_results();
    repeat (2) @(posedge clk_i);
    sample_scale_we_i <= 1'b1;
    sample_scale_i    <= value;
    @(posedge clk_i);
    sample_scale_we_i <= 1'b0;
    byte_sb.scale = value;
  endtask

  // Sum biased toward the range where the bytes do not saturate: an average
  // of 1.0 is reached at sum = 2^30 / scale. One in four is fully random so
  // that every input bit toggles.
  function automatic logic [pgq_pkg::SUM_BITS-1:0] random_sum(
      input logic [pgq_pkg::SCALE_WIDTH-1:0] scale);
    longint unsigned span;
    if (scale == 0 || $urandom_range(0, 3) == 0) return pgq_pkg::SUM_BITS'($urandom());
    span = (longint'(1) << (pgq_pkg::FRAC_BITS + pgq_pkg::SCALE_FRAC)) / scale;
    span = span + span / 8;
    if (span > (longint'(1) << pgq_pkg::SUM_BITS) - 1) begin
      span = (longint'(1) << pgq_pkg::SUM_BITS) - 1;
    end
    return pgq_pkg::SUM_BITS'($urandom_range(0, 32'(span)));
  endfunction

  // Random pixels at the current scale. With allow_idle the sender skips
  // about one cycle in ten; drain_at (if below count) empties the pipeline
  // once in the middle of the burst.
  task automatic random_pixels(input int unsigned count, input bit allow_idle,
                               input int unsigned drain_at);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == drain_at) drain_results();
      if (allow_idle && $urandom_range(0, 99) < 10) idle_cycles(1);
      send_pixel(random_sum(byte_sb.scale), random_sum(byte_sb.scale),
                 random_sum(byte_sb.scale));
    end
  endtask

  initial begin
    rst_ni            <= 1'b0;
    start_i           <= 1'b0;
    red_sum_i         <= '0;
    green_sum_i       <= '0;
    blue_sum_i        <= '0;
    sample_scale_we_i <= 1'b0;
    sample_scale_i    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pixels at the reset scale (one sample, Q1.16 = 1.0)
    send_pixel(24'h000000, 24'h000000, 24'h000000);  // black
    send_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);  // largest sums saturate
    send_pixel(24'h000001, 24'h000002, 24'h000003);  // smallest nonzero averages
    send_pixel(24'h004000, 24'h003FFF, 24'h004001);  // around an average of 1.0
    send_pixel(24'h001000, 24'h000400, 24'h000100);  // 1/4, 1/16, 1/64
    send_pixel(24'h002000, 24'h000800, 24'h000040);
    send_pixel(24'hAAAAAA, 24'h555555, 24'h000000);  // alternating bit patterns
    send_pixel(24'h555555, 24'hAAAAAA, 24'hFFFFFF);
    send_pixel(24'h000AAA, 24'h001555, 24'h003F00);
    send_pixel(24'h800000, 24'h008000, 24'h000080);  // single high bits
    send_pixel(24'h00000F, 24'h0000F0, 24'h000F00);
    idle_cycles(3);
    send_pixel(24'h000100, 24'h000000, 24'hFFFFFF);
    send_pixel(24'h003E03, 24'h003C10, 24'h0000C8);

    // Zero scale: everything is black, even the largest sums
    write_scale('0);
    send_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_pixel(24'h004000, 24'h123456, 24'h000001);
    random_pixels(50, 1'b1, 50);

    // Largest scale: a gain just under two; still saturates at 255
    write_scale(pgq_pkg::SCALE_WIDTH'(131071));
    send_pixel(24'h002000, 24'h001FFF, 24'hFFFFFF);
    send_pixel(24'h000001, 24'h000800, 24'h000000);
    random_pixels(110, 1'b1, 110);

    // Smallest practical scale: 1/1024 of a sample
    write_scale(pgq_pkg::SCALE_WIDTH'(64));
    send_pixel(24'hFFFFFF, 24'h7FFFFF, 24'h000001);
    random_pixels(110, 1'b1, 110);

    // Back to one sample, with a long stretch of pixels on every cycle
    write_scale(pgq_pkg::SCALE_RESET);
    random_pixels(270, 1'b0, 270);

    // Scale of one LSB: averages stay tiny
    write_scale(pgq_pkg::SCALE_WIDTH'(1));
    send_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    random_pixels(60, 1'b1, 60);

    // Three samples per pixel
    write_scale(pgq_pkg::SCALE_WIDTH'(21845));
    random_pixels(110, 1'b1, 110);

    // Random scale in the normal range, sender drains the pipeline midway
    write_scale(pgq_pkg::SCALE_WIDTH'($urandom_range(64, 65536)));
    random_pixels(110, 1'b1, 55);

    // Sixteen samples per pixel
    write_scale(pgq_pkg::SCALE_WIDTH'(4096));
    random_pixels(110, 1'b1, 110);

    // Wait for the last results, then give any stray done_o time to show up
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (byte_sb.fail_count == 0 && byte_sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
